>>> design/uart16550_pkg.sv
package uart16550_pkg;

    // Queue depth when the FIFO is enabled. Legal range is 1 to 64.
    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_BUS_READ  = 2'd0,
        OP_BUS_WRITE = 2'd1,
        OP_LINE_RDY  = 2'd2,
        OP_RX_BYTE   = 2'd3
    } op_t;

    // Register offsets of the standard map.
    localparam logic [2:0] ADDR_DATA = 3'd0;
    localparam logic [2:0] ADDR_IER  = 3'd1;
    localparam logic [2:0] ADDR_FCR  = 3'd2;
    localparam logic [2:0] ADDR_LCR  = 3'd3;
    localparam logic [2:0] ADDR_MCR  = 3'd4;
    localparam logic [2:0] ADDR_LSR  = 3'd5;
    localparam logic [2:0] ADDR_MSR  = 3'd6;
    localparam logic [2:0] ADDR_SCR  = 3'd7;

    localparam int LCR_DLAB_BIT   = 7;
    localparam int MCR_LOOP_BIT   = 4;
    localparam int FCR_EN_BIT     = 0;
    localparam int FCR_RXCLR_BIT  = 1;
    localparam int FCR_TXCLR_BIT  = 2;

    localparam logic [7:0] IIR_FIFO_ON  = 8'hC1;
    localparam logic [7:0] IIR_FIFO_OFF = 8'h01;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(FIFO_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

>>> design/uart_16550_register_model.sv
// A request accepted into the input register moves on to the result register,
// with m_valid high, once that register is empty or being drained.
// Throughput: one request per cycle. Requests stall only while m_ready holds a
// result back; the input register then keeps one waiting request.
// Reset: aresetn is synchronous and active low; it clears the valid flags, the
// UART registers, queue pointers and fill counts, but not the queue storage.
module uart_16550_register_model
    import uart16550_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic [2:0] s_addr,
    input  logic [7:0] s_wdata,
    input  logic [7:0] s_rx_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_rdata,
    output logic       m_tx_valid,
    output logic [7:0] m_tx_byte
);

    // ------------------------------------------------------------------
    // Handshake. The input register holds one request; it moves into the
    // result register whenever that register is empty or being drained.
    // A new request is taken in the same cycle the held one moves on.
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic advance;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;

    logic [1:0] op_reg;
    logic [2:0] addr_reg;
    logic [7:0] wdata_reg;
    logic [7:0] rx_byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg      <= s_op;
            addr_reg    <= s_addr;
            wdata_reg   <= s_wdata;
            rx_byte_reg <= s_rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // Architectural state.
    // ------------------------------------------------------------------
    logic [7:0]        dll_reg,  dll_next;
    logic [7:0]        dlh_reg,  dlh_next;
    logic [3:0]        ier_reg,  ier_next;
    logic [7:0]        lcr_reg,  lcr_next;
    logic [4:0]        mcr_reg,  mcr_next;
    logic              fifo_on_reg, fifo_on_next;
    logic [1:0]        trig_reg, trig_next;
    logic [7:0]        scr_reg,  scr_next;
    logic              ovr_reg,  ovr_next;

    // Both queues are circular buffers in flops, read only at the head.
    logic [7:0]        rx_mem_reg [FIFO_DEPTH];
    logic [7:0]        tx_mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [PTR_W-1:0]  tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [FILL_W-1:0] rx_fill_reg, rx_fill_next;
    logic [FILL_W-1:0] tx_fill_reg, tx_fill_next;

    // Queue write ports.
    logic              rx_we, tx_we;
    logic [PTR_W-1:0]  rx_waddr;
    logic [7:0]        rx_wdata;

    // Result of the request in the input register.
    logic [7:0]        rdata_c;
    logic              tx_valid_c;
    logic [7:0]        tx_byte_c;

    logic              dlab, loopback;
    logic              rx_full, tx_full, rx_empty, tx_empty;
    logic [7:0]        lsr_value;
    logic              rx_push, rx_pop, rx_clr;
    logic              tx_push, tx_pop, tx_clr;
    logic              rx_do, rx_overrun;
    logic [7:0]        rx_in;
    op_t               op;

    assign op       = op_t'(op_reg);
    assign dlab     = lcr_reg[LCR_DLAB_BIT];
    assign loopback = mcr_reg[MCR_LOOP_BIT];
    assign rx_empty = (rx_fill_reg == '0);
    assign tx_empty = (tx_fill_reg == '0);
    // With the FIFO off each queue holds a single byte.
    assign rx_full  = fifo_on_reg ? (rx_fill_reg == FILL_W'(FIFO_DEPTH)) : !rx_empty;
    assign tx_full  = fifo_on_reg ? (tx_fill_reg == FILL_W'(FIFO_DEPTH)) : !tx_empty;

    // Line status: data ready, overrun, and both transmitter-empty bits.
    assign lsr_value = {1'b0, tx_empty, tx_empty, 3'b000, ovr_reg, !rx_empty};

    always_comb begin
        dll_next     = dll_reg;
        dlh_next     = dlh_reg;
        ier_next     = ier_reg;
        lcr_next     = lcr_reg;
        mcr_next     = mcr_reg;
        fifo_on_next = fifo_on_reg;
        trig_next    = trig_reg;
        scr_next     = scr_reg;
        ovr_next     = ovr_reg;
        rx_pop       = 1'b0;
        rx_clr       = 1'b0;
        tx_push      = 1'b0;
        tx_pop       = 1'b0;
        tx_clr       = 1'b0;
        rx_do        = 1'b0;
        rx_in        = rx_byte_reg;
        rdata_c      = 8'h00;
        tx_valid_c   = 1'b0;
        tx_byte_c    = 8'h00;

        unique case (op)
            OP_BUS_READ: begin
                unique case (addr_reg)
                    ADDR_DATA: begin
                        if (dlab) begin
                            rdata_c = dll_reg;
                        end else if (!rx_empty) begin
                            rdata_c = rx_mem_reg[rx_head_reg];
                            rx_pop  = 1'b1;
                        end
                    end
                    ADDR_IER: rdata_c = dlab ? dlh_reg : {4'b0000, ier_reg};
                    ADDR_FCR: rdata_c = fifo_on_reg ? IIR_FIFO_ON : IIR_FIFO_OFF;
                    ADDR_LCR: rdata_c = lcr_reg;
                    ADDR_MCR: rdata_c = {3'b000, mcr_reg};
                    ADDR_LSR: begin
                        rdata_c  = lsr_value;
                        ovr_next = 1'b0;
                    end
                    ADDR_MSR: rdata_c = 8'h00;
                    ADDR_SCR: rdata_c = scr_reg;
                    default:  rdata_c = 8'h00;
                endcase
            end
            OP_BUS_WRITE: begin
                unique case (addr_reg)
                    ADDR_DATA: begin
                        if (dlab) begin
                            dll_next = wdata_reg;
                        end else if (loopback) begin
                            rx_do = 1'b1;
                            rx_in = wdata_reg;
                        end else if (!tx_full) begin
                            tx_push = 1'b1;
                        end
                    end
                    ADDR_IER: begin
                        if (dlab) begin
                            dlh_next = wdata_reg;
                        end else begin
                            ier_next = wdata_reg[3:0];
                        end
                    end
                    ADDR_FCR: begin
                        fifo_on_next = wdata_reg[FCR_EN_BIT];
                        trig_next    = wdata_reg[7:6];
                        if (wdata_reg[FCR_EN_BIT] != fifo_on_reg) begin
                            rx_clr = 1'b1;
                            tx_clr = 1'b1;
                        end
                        if (wdata_reg[FCR_RXCLR_BIT]) begin
                            rx_clr = 1'b1;
                        end
                        if (wdata_reg[FCR_TXCLR_BIT]) begin
                            tx_clr = 1'b1;
                        end
                    end
                    ADDR_LCR: lcr_next = wdata_reg;
                    ADDR_MCR: mcr_next = wdata_reg[4:0];
                    ADDR_LSR: ;
                    ADDR_MSR: ;
                    ADDR_SCR: scr_next = wdata_reg;
                    default: ;
                endcase
            end
            OP_LINE_RDY: begin
                if (!loopback && !tx_empty) begin
                    tx_pop     = 1'b1;
                    tx_valid_c = 1'b1;
                    tx_byte_c  = tx_mem_reg[tx_head_reg];
                end
            end
            OP_RX_BYTE: begin
                rx_do = !loopback;
            end
            default: ;
        endcase

        // Receive path shared by the line input and loopback writes.
        if (rx_do && rx_full) begin
            ovr_next = 1'b1;
        end
    end

    assign rx_push    = rx_do && !rx_full;
    // With the FIFO off a byte arriving at a full queue replaces the held one.
    assign rx_overrun = rx_do && rx_full && !fifo_on_reg;
    assign rx_we      = rx_push || rx_overrun;
    assign rx_waddr   = rx_push ? rx_tail_reg : rx_head_reg;
    assign rx_wdata   = rx_in;
    assign tx_we      = tx_push;

    // Pointer and fill updates. Push, pop and clear never meet in one request.
    always_comb begin
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        rx_fill_next = rx_fill_reg;
        if (rx_clr) begin
            rx_head_next = '0;
            rx_tail_next = '0;
            rx_fill_next = '0;
        end else if (rx_push) begin
            rx_tail_next = ptr_inc(rx_tail_reg);
            rx_fill_next = rx_fill_reg + FILL_W'(1);
        end else if (rx_pop) begin
            rx_head_next = ptr_inc(rx_head_reg);
            rx_fill_next = rx_fill_reg - FILL_W'(1);
        end

        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        tx_fill_next = tx_fill_reg;
        if (tx_clr) begin
            tx_head_next = '0;
            tx_tail_next = '0;
            tx_fill_next = '0;
        end else if (tx_push) begin
            tx_tail_next = ptr_inc(tx_tail_reg);
            tx_fill_next = tx_fill_reg + FILL_W'(1);
        end else if (tx_pop) begin
            tx_head_next = ptr_inc(tx_head_reg);
            tx_fill_next = tx_fill_reg - FILL_W'(1);
        end
    end

    // State only moves when the request leaves the input register, so the
    // order of updates is exactly the order of requests.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dll_reg     <= '0;
            dlh_reg     <= '0;
            ier_reg     <= '0;
            lcr_reg     <= '0;
            mcr_reg     <= '0;
            fifo_on_reg <= 1'b0;
            trig_reg    <= '0;
            scr_reg     <= '0;
            ovr_reg     <= 1'b0;
            rx_head_reg <= '0;
            rx_tail_reg <= '0;
            rx_fill_reg <= '0;
            tx_head_reg <= '0;
            tx_tail_reg <= '0;
            tx_fill_reg <= '0;
        end else if (advance) begin
            dll_reg     <= dll_next;
            dlh_reg     <= dlh_next;
            ier_reg     <= ier_next;
            lcr_reg     <= lcr_next;
            mcr_reg     <= mcr_next;
            fifo_on_reg <= fifo_on_next;
            trig_reg    <= trig_next;
            scr_reg     <= scr_next;
            ovr_reg     <= ovr_next;
            rx_head_reg <= rx_head_next;
            rx_tail_reg <= rx_tail_next;
            rx_fill_reg <= rx_fill_next;
            tx_head_reg <= tx_head_next;
            tx_tail_reg <= tx_tail_next;
            tx_fill_reg <= tx_fill_next;
        end
    end

    // Queue storage carries no reset.
    always_ff @(posedge aclk) begin
        if (advance && rx_we) begin
            rx_mem_reg[rx_waddr] <= rx_wdata;
        end
        if (advance && tx_we) begin
            tx_mem_reg[tx_tail_reg] <= wdata_reg;
        end
    end

    // Result register.
    logic [7:0] m_rdata_reg;
    logic       m_tx_valid_reg;
    logic [7:0] m_tx_byte_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_rdata_reg    <= rdata_c;
            m_tx_valid_reg <= tx_valid_c;
            m_tx_byte_reg  <= tx_byte_c;
        end
    end

    assign m_rdata    = m_rdata_reg;
    assign m_tx_valid = m_tx_valid_reg;
    assign m_tx_byte  = m_tx_byte_reg;

endmodule
